[rtl/core/bba_pkg.sv]
package bba_pkg;

   // Fixed field widths of the ports.
   localparam int ORD_W  = 5;
   localparam int ADDR_W = 10;
   localparam int SIZE_W = 11;
   localparam int POOL_W = 4;
   localparam int STAT_W = 2;

   // Tree node codes.
   localparam logic [1:0] NS_UNUSED = 2'd0;
   localparam logic [1:0] NS_FREE   = 2'd1;
   localparam logic [1:0] NS_SPLIT  = 2'd2;
   localparam logic [1:0] NS_ALLOC  = 2'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_CHK, S_SPLIT_R,
      S_AO_CHK, S_FN_RD, S_FN_CHK, S_MRG, S_MRG_CHK, S_MRG_B, S_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_CLR_STEP, OP_LOAD, OP_FAIL, OP_SCAN_INIT, OP_RD_NODE, OP_SCAN_NEXT,
      OP_FOUND, OP_WR_SPLIT, OP_WR_RIGHT, OP_WR_ALLOC, OP_RD_AO, OP_FREE_SETUP,
      OP_WR_AO_ZERO, OP_RD_BUDDY, OP_WR_N_UNUSED, OP_WR_B_UNUSED, OP_WR_N_FREE,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [STAT_W-1:0]  code;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_free_req;
      logic k_too_big;
      logic addr_bad;
      logic scan_last;
      logic depth_zero;
      logic node_free;
      logic node_alloc;
      logic o_gt_k;
      logic ao_bad;
      logic n_root;
      logic out_busy;
   } dp_sts_type;

   // Order of the smallest power of two not below size; zero maps to order 0.
   function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
      logic [ORD_W-1:0] k;
      k = '0;
      for (int j = 0; j < SIZE_W; j++) begin
         if (((SIZE_W+1)'(1) << j) < {1'b0, size}) begin
            k = ORD_W'(j + 1);
         end
      end
      return k;
   endfunction

endpackage

[rtl/core/bba_ram.sv]
module bba_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/bba_datapath.sv]
module bba_datapath
   import bba_pkg::*;
#(
   parameter int LEVELS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic                 req_action,
   input  logic [SIZE_W-1:0]    req_size_units,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    rsp_block_address,
   output logic [SIZE_W-1:0]    rsp_block_size,
   output logic [STAT_W-1:0]    rsp_status,
   output logic                 rsp_pool_all_free,
   input  logic                 csr_wr_en,
   input  logic [POOL_W-1:0]    csr_wr_data
);

   localparam int NW    = LEVELS + 1;
   localparam int UW    = LEVELS;
   localparam int NODES = 2**NW - 1;
   localparam int UNITS = 2**UW;

   logic [ORD_W-1:0]  pool_ff;
   logic [NW-1:0]     clr_ff;
   logic              action_ff;
   logic [ORD_W-1:0]  k_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [NW-1:0]     n_ff;
   logic [ORD_W-1:0]  depth_ff;
   logic [ORD_W-1:0]  o_ff;
   logic [UW-1:0]     res_addr_ff;
   logic              root_free_ff;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_free_ff;
   logic              fail_ff;
   logic [STAT_W-1:0] stat_ff;

   logic [ORD_W-1:0]  pool_in;
   logic [NW-1:0]     first_d;
   logic [NW-1:0]     last_d;
   logic [NW-1:0]     buddy;
   logic [NW-1:0]     parent;
   logic [NW-1:0]     left;
   logic [UW-1:0]     addr_u;
   logic [ORD_W-1:0]  ao_o;
   logic [ORD_W-1:0]  setup_depth;

   logic              nd_we;
   logic [NW-1:0]     nd_waddr;
   logic [1:0]        nd_wdata;
   logic [NW-1:0]     nd_raddr;
   logic [1:0]        nd_rd;
   logic              ao_we;
   logic [UW-1:0]     ao_waddr;
   logic [ORD_W-1:0]  ao_wdata;
   logic [ORD_W-1:0]  ao_rd;

   // Tree arithmetic on the current node.
   assign first_d     = (NW'(1) << depth_ff) - NW'(1);
   assign last_d      = (NW'(2) << depth_ff) - NW'(2);
   assign buddy       = ((n_ff - NW'(1)) ^ NW'(1)) + NW'(1);
   assign parent      = (n_ff - NW'(1)) >> 1;
   assign left        = (n_ff << 1) + NW'(1);
   assign addr_u      = UW'(addr_ff);
   assign ao_o        = ao_rd - ORD_W'(1);
   assign setup_depth = pool_ff - ao_o;
   assign pool_in     = ({1'b0, csr_wr_data} > ORD_W'(LEVELS)) ? ORD_W'(LEVELS)
                                                               : ORD_W'(csr_wr_data);

   // Status toward the controller.
   always_comb begin
      sts.clr_last    = (clr_ff == NW'(NODES - 1));
      sts.is_free_req = action_ff;
      sts.k_too_big   = (k_ff > pool_ff);
      sts.addr_bad    = ((addr_ff >> pool_ff) != '0);
      sts.scan_last   = (n_ff == last_d);
      sts.depth_zero  = (depth_ff == '0);
      sts.node_free   = (nd_rd == NS_FREE);
      sts.node_alloc  = (nd_rd == NS_ALLOC);
      sts.o_gt_k      = (o_ff > k_ff);
      sts.ao_bad      = (ao_rd == '0) || (ao_o > pool_ff);
      sts.n_root      = (n_ff == '0);
      sts.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   // Node memory write and read selection.
   always_comb begin
      nd_we    = 1'b1;
      nd_waddr = n_ff;
      nd_wdata = NS_UNUSED;
      case (cmd.op)
         OP_CLR_STEP: begin
            nd_waddr = clr_ff;
            nd_wdata = (clr_ff == '0) ? NS_FREE : NS_UNUSED;
         end
         OP_WR_SPLIT:    nd_wdata = NS_SPLIT;
         OP_WR_RIGHT: begin
            nd_waddr = left + NW'(1);
            nd_wdata = NS_FREE;
         end
         OP_WR_ALLOC:    nd_wdata = NS_ALLOC;
         OP_WR_N_UNUSED: nd_wdata = NS_UNUSED;
         OP_WR_B_UNUSED: nd_waddr = buddy;
         OP_WR_N_FREE:   nd_wdata = NS_FREE;
         default:        nd_we = 1'b0;
      endcase
   end

   assign nd_raddr = (cmd.op == OP_RD_BUDDY) ? buddy : n_ff;

   // Allocation order memory write selection.
   always_comb begin
      ao_we    = 1'b1;
      ao_waddr = addr_u;
      ao_wdata = '0;
      case (cmd.op)
         OP_CLR_STEP:   ao_waddr = clr_ff[UW-1:0];
         OP_WR_ALLOC: begin
            ao_waddr = res_addr_ff;
            ao_wdata = o_ff + ORD_W'(1);
         end
         OP_WR_AO_ZERO: ao_wdata = '0;
         default:       ao_we = 1'b0;
      endcase
   end

   bba_ram #(.WIDTH(2), .DEPTH(NODES)) u_node_ram (
      .clock (clock),
      .we    (nd_we),
      .waddr (nd_waddr),
      .wdata (nd_wdata),
      .raddr (nd_raddr),
      .rdata (nd_rd)
   );

   bba_ram #(.WIDTH(ORD_W), .DEPTH(UNITS)) u_order_ram (
      .clock (clock),
      .we    (ao_we),
      .waddr (ao_waddr),
      .wdata (ao_wdata),
      .raddr (addr_u),
      .rdata (ao_rd)
   );

   // Control registers: pool size, clearing sweep, root flag, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= ORD_W'(LEVELS);
         clr_ff       <= '0;
         root_free_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_ff <= pool_in;
            clr_ff  <= '0;
         end else if (cmd.op == OP_CLR_STEP) begin
            clr_ff <= sts.clr_last ? '0 : clr_ff + NW'(1);
         end
         if (nd_we && nd_waddr == '0) begin
            root_free_ff <= (nd_wdata == NS_FREE);
         end
         if (cmd.op == OP_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the current word.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            action_ff <= req_action;
            k_ff      <= size_order(req_size_units);
            addr_ff   <= req_address;
            fail_ff   <= 1'b0;
            stat_ff   <= ST_OK;
         end
         OP_FAIL: begin
            fail_ff <= 1'b1;
            stat_ff <= cmd.code;
         end
         OP_SCAN_INIT: begin
            depth_ff <= pool_ff - k_ff;
            n_ff     <= (NW'(1) << (pool_ff - k_ff)) - NW'(1);
         end
         OP_SCAN_NEXT: begin
            if (sts.scan_last) begin
               depth_ff <= depth_ff - ORD_W'(1);
               n_ff     <= (NW'(1) << (depth_ff - ORD_W'(1))) - NW'(1);
            end else begin
               n_ff <= n_ff + NW'(1);
            end
         end
         OP_FOUND: begin
            o_ff        <= pool_ff - depth_ff;
            res_addr_ff <= UW'(n_ff - first_d) << (pool_ff - depth_ff);
         end
         OP_WR_RIGHT: begin
            n_ff     <= left;
            depth_ff <= depth_ff + ORD_W'(1);
            o_ff     <= o_ff - ORD_W'(1);
         end
         OP_FREE_SETUP: begin
            o_ff        <= ao_o;
            depth_ff    <= setup_depth;
            n_ff        <= ((NW'(1) << setup_depth) - NW'(1)) + NW'(addr_u >> ao_o);
            res_addr_ff <= addr_u;
         end
         OP_WR_B_UNUSED: n_ff <= parent;
         OP_PUBLISH: begin
            rsp_addr_ff   <= fail_ff ? '0 : ADDR_W'(res_addr_ff);
            rsp_size_ff   <= fail_ff ? '0 : (SIZE_W'(1) << o_ff);
            rsp_status_ff <= stat_ff;
            rsp_free_ff   <= root_free_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_block_size    = rsp_size_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_pool_all_free = rsp_free_ff;

`ifndef ASSERT_OFF
   // A block is taken only where the search read a free node.
   a_found_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FOUND) |-> (nd_rd == NS_FREE))
      else $error("allocation took a node that is not free");

   // The search starts only for a size the pool can hold.
   a_scan_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SCAN_INIT) |-> (k_ff <= pool_ff))
      else $error("search started for an oversized request");
`endif

endmodule

[rtl/core/bba_ctrl.sv]
module bba_ctrl
   import bba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       csr_wr_en,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:     if (sts.clr_last) state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (sts.is_free_req) begin
               state_in = sts.addr_bad ? S_FIN : S_AO_CHK;
            end else begin
               state_in = sts.k_too_big ? S_FIN : S_SCAN_RD;
            end
         end
         S_SCAN_RD:   state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (sts.node_free) begin
               state_in = S_SPLIT_CHK;
            end else if (sts.scan_last && sts.depth_zero) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SPLIT_CHK: state_in = sts.o_gt_k ? S_SPLIT_R : S_FIN;
         S_SPLIT_R:   state_in = S_SPLIT_CHK;
         S_AO_CHK:    state_in = sts.ao_bad ? S_FIN : S_FN_RD;
         S_FN_RD:     state_in = S_FN_CHK;
         S_FN_CHK:    state_in = sts.node_alloc ? S_MRG : S_FIN;
         S_MRG:       state_in = sts.n_root ? S_FIN : S_MRG_CHK;
         S_MRG_CHK:   state_in = sts.node_free ? S_MRG_B : S_FIN;
         S_MRG_B:     state_in = S_MRG;
         S_FIN:       if (!sts.out_busy) state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
      if (csr_wr_en) begin
         state_in = S_CLEAR;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op    = OP_NOP;
      cmd.code  = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR:     cmd.op = OP_CLR_STEP;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_DISPATCH: begin
            if (sts.is_free_req) begin
               if (sts.addr_bad) begin
                  cmd.op   = OP_FAIL;
                  cmd.code = ST_BADADDR;
               end else begin
                  cmd.op = OP_RD_AO;
               end
            end else if (sts.k_too_big) begin
               cmd.op   = OP_FAIL;
               cmd.code = ST_NOFIT;
            end else begin
               cmd.op = OP_SCAN_INIT;
            end
         end
         S_SCAN_RD:   cmd.op = OP_RD_NODE;
         S_SCAN_CHK: begin
            if (sts.node_free) begin
               cmd.op = OP_FOUND;
            end else if (sts.scan_last && sts.depth_zero) begin
               cmd.op   = OP_FAIL;
               cmd.code = ST_NOFIT;
            end else begin
               cmd.op = OP_SCAN_NEXT;
            end
         end
         S_SPLIT_CHK: cmd.op = sts.o_gt_k ? OP_WR_SPLIT : OP_WR_ALLOC;
         S_SPLIT_R:   cmd.op = OP_WR_RIGHT;
         S_AO_CHK: begin
            if (sts.ao_bad) begin
               cmd.op   = OP_FAIL;
               cmd.code = ST_BADADDR;
            end else begin
               cmd.op = OP_FREE_SETUP;
            end
         end
         S_FN_RD:     cmd.op = OP_RD_NODE;
         S_FN_CHK: begin
            if (sts.node_alloc) begin
               cmd.op = OP_WR_AO_ZERO;
            end else begin
               cmd.op   = OP_FAIL;
               cmd.code = ST_BADADDR;
            end
         end
         S_MRG:       cmd.op = sts.n_root ? OP_WR_N_FREE : OP_RD_BUDDY;
         S_MRG_CHK:   cmd.op = sts.node_free ? OP_WR_N_UNUSED : OP_WR_N_FREE;
         S_MRG_B:     cmd.op = OP_WR_B_UNUSED;
         S_FIN:       if (!sts.out_busy) cmd.op = OP_PUBLISH;
         default:     cmd.op = OP_NOP;
      endcase
   end

`ifndef ASSERT_OFF
   // A pool size write always restarts the clearing sweep.
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (state_ff == S_CLEAR))
      else $error("pool size write did not start clearing");

   // A result is never pushed into an occupied output register.
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |-> !sts.out_busy)
      else $error("result published while output register busy");
`endif

endmodule

[rtl/core/binary_buddy_allocator.sv]
// Allocate searches the tree, visiting nodes one memory read at a time, up to
// 2^(LEVELS+1)-1 nodes, then splits down. Free merges upward level by level
// (one node memory port).
// One word at a time; the next is accepted while a result waits in the output register.
// Reset and every pool_order write run a clearing sweep over all 2^(LEVELS+1)-1 tree nodes
// (2047 at LEVELS = 10) during which no word is accepted.
module binary_buddy_allocator
   import bba_pkg::*;
#(
   parameter int LEVELS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [SIZE_W-1:0] req_size_units,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_block_address,
   output logic [SIZE_W-1:0] rsp_block_size,
   output logic [STAT_W-1:0] rsp_status,
   output logic              rsp_pool_all_free,
   input  logic              csr_wr_en,
   input  logic [POOL_W-1:0] csr_wr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_wr_en (csr_wr_en),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Tree memories, working registers and output register.
   bba_datapath #(.LEVELS(LEVELS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_size_units    (req_size_units),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_block_address (rsp_block_address),
      .rsp_block_size    (rsp_block_size),
      .rsp_status        (rsp_status),
      .rsp_pool_all_free (rsp_pool_all_free),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

endmodule

[tb/sv/bba_checker.sv]
module bba_checker
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_action,
   input  logic [SIZE_W-1:0] req_size_units,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [ADDR_W-1:0] rsp_block_address,
   input  logic [SIZE_W-1:0] rsp_block_size,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic              rsp_pool_all_free,
   input  logic              csr_wr_en,
   input  logic [POOL_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                grant_pending
);

   localparam int TREE_LEVELS = 10;
   localparam int NODE_TOTAL  = (2 << TREE_LEVELS) - 1;
   localparam int UNIT_TOTAL  = 1 << TREE_LEVELS;

   typedef struct {
      logic [ADDR_W-1:0] block_address;
      logic [SIZE_W-1:0] block_size;
      logic [STAT_W-1:0] status;
      logic              all_free;
   } grant_word_type;

   // Shadow copy of the buddy tree and allocation table.
   logic [1:0]     tree_node [NODE_TOTAL];
   logic [3:0]     start_order [UNIT_TOTAL];
   int             pool_ord;
   grant_word_type grant_q [$];

   assign grant_pending = grant_q.size();

   task automatic clear_tree();
      for (int i = 0; i < NODE_TOTAL; i++) tree_node[i] = NS_UNUSED;
      for (int i = 0; i < UNIT_TOTAL; i++) start_order[i] = '0;
      tree_node[0] = NS_FREE;
   endtask

   // Allocation: smallest free block that fits, lowest address first, then split down.
   task automatic model_alloc(input int size, output grant_word_type w);
      int k, d, n, depth, o, first;
      bit found;
      int addr;
      k = 0;
      found = 0;
      n = 0;
      depth = 0;
      if (size == 0) size = 1;
      while (k < 31 && (1 << k) < size) k++;
      w.block_address = '0;
      w.block_size    = '0;
      w.status        = ST_NOFIT;
      if (k <= pool_ord) begin
         for (d = pool_ord - k; d >= 0 && !found; d--) begin
            first = (1 << d) - 1;
            for (int i = 0; i < (1 << d); i++) begin
               if (tree_node[first + i] == NS_FREE) begin
                  n = first + i;
                  depth = d;
                  found = 1;
                  break;
               end
            end
         end
         if (found) begin
            o = pool_ord - depth;
            while (o > k) begin
               tree_node[n] = NS_SPLIT;
               tree_node[2 * n + 2] = NS_FREE;
               n = 2 * n + 1;
               tree_node[n] = NS_FREE;
               depth++;
               o--;
            end
            tree_node[n] = NS_ALLOC;
            addr = (n - ((1 << depth) - 1)) << o;
            start_order[addr] = 4'(o + 1);
            w.block_address = ADDR_W'(addr);
            w.block_size    = SIZE_W'(1 << o);
            w.status        = ST_OK;
         end
      end
      w.all_free = (tree_node[0] == NS_FREE);
   endtask

   // Release: find the block by its start, then merge with free buddies upward.
   task automatic model_free(input int addr, output grant_word_type w);
      int o, n, b;
      w.block_address = '0;
      w.block_size    = '0;
      w.status        = ST_BADADDR;
      if (addr < (1 << pool_ord) && start_order[addr] != 0) begin
         o = int'(start_order[addr]) - 1;
         n = (1 << (pool_ord - o)) - 1 + (addr >> o);
         if (o <= pool_ord && n < NODE_TOTAL && tree_node[n] == NS_ALLOC) begin
            start_order[addr] = '0;
            tree_node[n] = NS_FREE;
            while (n > 0) begin
               b = ((n - 1) ^ 1) + 1;
               if (tree_node[b] != NS_FREE) break;
               tree_node[n] = NS_UNUSED;
               tree_node[b] = NS_UNUSED;
               n = (n - 1) / 2;
               tree_node[n] = NS_FREE;
            end
            w.block_address = ADDR_W'(addr);
            w.block_size    = SIZE_W'(1 << o);
            w.status        = ST_OK;
         end
      end
      w.all_free = (tree_node[0] == NS_FREE);
   endtask

   // Predict on every accepted request word, compare on every accepted result word.
   always @(posedge clock) begin
      grant_word_type w;
      if (reset) begin
         pool_ord = TREE_LEVELS;
         clear_tree();
         grant_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            pool_ord = (csr_wr_data > TREE_LEVELS) ? TREE_LEVELS : int'(csr_wr_data);
            clear_tree();
         end
         if (req_valid && req_ready) begin
            if (req_action) model_free(int'(req_address), w);
            else model_alloc(int'(req_size_units), w);
            grant_q.push_back(w);
         end
         if (rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               $display("%0t: unexpected result word addr=%0d size=%0d status=%0d",
                        $time, rsp_block_address, rsp_block_size, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               w = grant_q.pop_front();
               if (rsp_block_address !== w.block_address || rsp_block_size !== w.block_size
                   || rsp_status !== w.status || rsp_pool_all_free !== w.all_free) begin
                  $display("%0t: mismatch expected addr=%0d size=%0d status=%0d free=%0b",
                           $time, w.block_address, w.block_size, w.status, w.all_free);
                  $display("%0t:          actual   addr=%0d size=%0d status=%0d free=%0b",
                           $time, rsp_block_address, rsp_block_size, rsp_status,
                           rsp_pool_all_free);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/sv/tb_binary_buddy_allocator.sv]
module tb_binary_buddy_allocator;
   import bba_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = 1'b0;
   logic [SIZE_W-1:0] req_size_units = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_block_address;
   logic [SIZE_W-1:0] rsp_block_size;
   logic [STAT_W-1:0] rsp_status;
   logic              rsp_pool_all_free;
   logic              csr_wr_en = 1'b0;
   logic [POOL_W-1:0] csr_wr_data = '0;

   int fail_count;
   int grant_pending;
   int cur_order = 10;
   int idle_cycles = 0;
   bit quiet = 0;
   bit hold_rsp = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binary_buddy_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_size_units(req_size_units), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_block_address(rsp_block_address), .rsp_block_size(rsp_block_size),
      .rsp_status(rsp_status), .rsp_pool_all_free(rsp_pool_all_free),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   bba_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_size_units(req_size_units), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_block_address(rsp_block_address), .rsp_block_size(rsp_block_size),
      .rsp_status(rsp_status), .rsp_pool_all_free(rsp_pool_all_free),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .grant_pending(grant_pending)
   );

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Result side: random gaps, plus one long hold-off when requested.
   initial begin
      int gap;
      bit ok;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         gap = quiet ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            ok = rsp_valid;
            @(posedge clock);
         end while (!ok);
      end
   end

   // Offer one request word after a random gap and wait for its acceptance.
   task automatic send_word(input bit act, input int size, input int addr);
      int gap;
      bit ok;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_size_units <= SIZE_W'(size);
      req_address    <= ADDR_W'(addr);
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grant_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Pool order write while the block is idle.
   task automatic write_order(input int value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= POOL_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_order = (value > 10) ? 10 : value;
   endtask

   // Random traffic: mostly allocations and frees of plausible blocks, some noise.
   task automatic random_phase(input int count, input int min_k, input int alloc_pct);
      int k, size, addr, j;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && $urandom_range(0, 1)) begin
            drain();
         end
         if ($urandom_range(0, 99) < alloc_pct) begin
            if ($urandom_range(0, 15) == 0) begin
               size = $urandom_range(0, 2047);
            end else begin
               k = $urandom_range((min_k > cur_order) ? cur_order : min_k, cur_order);
               size = $urandom_range((1 << k) / 2, 1 << k);
            end
            send_word(1'b0, size, $urandom_range(0, 1023));
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               addr = $urandom_range(0, 1023);
            end else begin
               addr = $urandom_range(0, (1 << cur_order) - 1);
               j = $urandom_range(0, (cur_order < 3) ? cur_order : 3);
               addr = (addr >> j) << j;
            end
            send_word(1'b1, $urandom_range(0, 2047), addr);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero size, rounding, exhaustion, oversize, bad and double frees.
      quiet = 1;
      send_word(1'b0, 0, 0);
      send_word(1'b0, 1, 0);
      send_word(1'b0, 3, 0);
      send_word(1'b0, 1024, 0);
      send_word(1'b0, 2047, 1023);
      send_word(1'b1, 0, 1023);
      send_word(1'b1, 0, 2);
      send_word(1'b1, 0, 0);
      send_word(1'b1, 0, 1);
      send_word(1'b1, 0, 1);
      send_word(1'b1, 0, 4);
      send_word(1'b0, 1024, 0);
      send_word(1'b0, 1, 0);
      send_word(1'b1, 0, 0);
      send_word(1'b0, 512, 0);
      send_word(1'b0, 513, 0);
      send_word(1'b1, 2047, 512);
      send_word(1'b1, 0, 0);
      write_order(0);
      send_word(1'b0, 1, 0);
      send_word(1'b0, 2, 0);
      send_word(1'b1, 0, 0);
      send_word(1'b1, 0, 1);
      write_order(15);
      send_word(1'b0, 1024, 0);
      send_word(1'b1, 0, 0);

      // Random phases over several pool sizes.
      quiet = 0;
      write_order(4);
      random_phase(200, 0, 60);
      write_order(6);
      hold_rsp = 1;
      random_phase(200, 0, 65);
      write_order(3);
      quiet = 1;
      random_phase(150, 0, 55);
      quiet = 0;
      write_order(5);
      random_phase(200, 0, 60);
      write_order(1);
      random_phase(100, 0, 50);
      write_order(10);
      random_phase(60, 5, 60);
      write_order(2);
      random_phase(120, 0, 55);
      write_order(6);
      random_phase(200, 0, 70);
      write_order(15);
      random_phase(40, 6, 60);
      drain();

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_datapath.sv
rtl/core/bba_ctrl.sv
rtl/core/binary_buddy_allocator.sv
tb/sv/bba_checker.sv
tb/sv/tb_binary_buddy_allocator.sv
